// ===== design/bbms_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte block merge sorter package
// Shared constants, types and a helper function for the sorter and its RAMs.
// ----------------------------------------------------------------------------
package bbms_pkg;

    localparam int BLOCK_SIZE = 16;
    localparam int IDX_W      = (BLOCK_SIZE > 1) ? $clog2(BLOCK_SIZE) : 1;
    localparam int CNT_W      = $clog2(BLOCK_SIZE + 1);
    localparam int PTR_W      = CNT_W + 2;

    localparam logic [CNT_W-1:0] BLOCK_N  = CNT_W'(BLOCK_SIZE);
    localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(BLOCK_SIZE - 1);

    typedef logic [7:0]       t_byte;
    typedef logic [IDX_W-1:0] t_addr;
    typedef logic [CNT_W-1:0] t_cnt;
    typedef logic [PTR_W-1:0] t_ptr;

    typedef struct packed {
        logic  en;
        t_addr addr;
        t_byte data;
    } t_ram_wr;

    // Clips a run boundary to the end of the block.
    function automatic t_cnt clip_to_block(input t_ptr x);
        t_cnt r;
        if (x > t_ptr'(BLOCK_SIZE)) begin
            r = BLOCK_N;
        end else begin
            r = x[CNT_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== design/bbms_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block RAM with one write port and two read ports
// Holds one block of bytes; both read ports return registered data.
// ----------------------------------------------------------------------------
module bbms_ram
    import bbms_pkg::*;
(
    input  logic    i_clk,
    input  t_ram_wr i_wr,
    input  t_addr   i_rd_addr_a,
    input  t_addr   i_rd_addr_b,
    output t_byte   o_rd_data_a,
    output t_byte   o_rd_data_b
);

    t_byte r_mem [BLOCK_SIZE];

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        o_rd_data_a <= r_mem[i_rd_addr_a];
        o_rd_data_b <= r_mem[i_rd_addr_b];
    end

endmodule

// ===== design/byte_block_merge_sorter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte block merge sorter
// Loads a block of bytes, sorts it ascending by bottom-up merge sort and
// streams the sorted block out.
// ----------------------------------------------------------------------------
// A load transaction takes place at a rising edge with start high and busy
// low; one byte is accepted per cycle while loading. When the last byte of
// the block is accepted, busy rises and the block is sorted between two
// RAMs in ping-pong fashion, one merge pass per run width. Each pass starts
// with a priming state for the registered RAM read and then merges one
// element per cycle; there are ceil(log2(BLOCK_SIZE)) passes. The sorted
// bytes then leave on consecutive cycles after another priming state for
// the read, each marked by o_valid for one cycle, the last one with
// o_last_of_block. The receiver cannot stall; results are presented once.
// Reset clears the load count and the state machine; RAM contents are not
// cleared and are never read before they are written.
// ----------------------------------------------------------------------------
module byte_block_merge_sorter
    import bbms_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  start,
    input  t_byte i_data_byte,
    output logic  busy,
    output logic  o_valid,
    output t_byte o_sorted_byte,
    output logic  o_last_of_block
);

    typedef enum logic [4:0] {
        S_LOAD   = 5'b00001,
        S_MPRIME = 5'b00010,
        S_MERGE  = 5'b00100,
        S_EPRIME = 5'b01000,
        S_EMIT   = 5'b10000
    } t_state;

    t_state r_state, n_state;
    t_cnt   r_load_cnt, n_load_cnt;
    t_cnt   r_a, n_a;
    t_cnt   r_b, n_b;
    t_cnt   r_mid, n_mid;
    t_cnt   r_hi, n_hi;
    t_cnt   r_wp, n_wp;
    t_cnt   r_w, n_w;
    logic   r_src, n_src;
    logic   r_o_valid;
    logic   r_o_last;
    t_byte  r_o_byte;

    t_ram_wr smp_wr, scr_wr;
    t_byte   smp_qa, smp_qb, scr_qa, scr_qb;
    t_byte   qa, qb;
    logic    take_a;
    logic    load_acc;
    t_ptr    dbl_w;

    bbms_ram u_sample (
        .i_clk       (i_clk),
        .i_wr        (smp_wr),
        .i_rd_addr_a (n_a[IDX_W-1:0]),
        .i_rd_addr_b (n_b[IDX_W-1:0]),
        .o_rd_data_a (smp_qa),
        .o_rd_data_b (smp_qb)
    );

    bbms_ram u_scratch (
        .i_clk       (i_clk),
        .i_wr        (scr_wr),
        .i_rd_addr_a (n_a[IDX_W-1:0]),
        .i_rd_addr_b (n_b[IDX_W-1:0]),
        .o_rd_data_a (scr_qa),
        .o_rd_data_b (scr_qb)
    );

    assign busy     = (r_state != S_LOAD);
    assign load_acc = start && !busy;
    assign qa       = r_src ? scr_qa : smp_qa;
    assign qb       = r_src ? scr_qb : smp_qb;
    assign take_a   = (r_a < r_mid) && ((r_b >= r_hi) || (qa <= qb));
    assign dbl_w    = {1'b0, r_w, 1'b0};

    always_comb begin
        smp_wr.en   = load_acc || ((r_state == S_MERGE) && r_src);
        smp_wr.addr = load_acc ? r_load_cnt[IDX_W-1:0] : r_wp[IDX_W-1:0];
        smp_wr.data = load_acc ? i_data_byte : (take_a ? qa : qb);
        scr_wr.en   = (r_state == S_MERGE) && !r_src;
        scr_wr.addr = r_wp[IDX_W-1:0];
        scr_wr.data = take_a ? qa : qb;
    end

    always_comb begin
        n_state    = r_state;
        n_load_cnt = r_load_cnt;
        n_a        = r_a;
        n_b        = r_b;
        n_mid      = r_mid;
        n_hi       = r_hi;
        n_wp       = r_wp;
        n_w        = r_w;
        n_src      = r_src;
        unique case (r_state)
            S_LOAD: begin
                if (load_acc) begin
                    if (r_load_cnt == LAST_IDX) begin
                        n_load_cnt = '0;
                        n_src      = 1'b0;
                        n_a        = '0;
                        n_wp       = '0;
                        n_w        = t_cnt'(1);
                        n_b        = clip_to_block(t_ptr'(1));
                        n_mid      = clip_to_block(t_ptr'(1));
                        n_hi       = clip_to_block(t_ptr'(2));
                        n_state    = (BLOCK_SIZE > 1) ? S_MPRIME : S_EPRIME;
                    end else begin
                        n_load_cnt = r_load_cnt + t_cnt'(1);
                    end
                end
            end
            S_MPRIME: begin
                n_state = S_MERGE;
            end
            S_MERGE: begin
                if (take_a) begin
                    n_a = r_a + t_cnt'(1);
                end else begin
                    n_b = r_b + t_cnt'(1);
                end
                n_wp = r_wp + t_cnt'(1);
                if (r_wp == LAST_IDX) begin
                    n_src = !r_src;
                    n_wp  = '0;
                    n_a   = '0;
                    n_w   = dbl_w[CNT_W-1:0];
                    n_b   = clip_to_block(dbl_w);
                    n_mid = clip_to_block(dbl_w);
                    n_hi  = clip_to_block(t_ptr'({dbl_w, 1'b0}));
                    if (dbl_w >= t_ptr'(BLOCK_SIZE)) begin
                        n_state = S_EPRIME;
                    end else begin
                        n_state = S_MPRIME;
                    end
                end else if (n_wp == r_hi) begin
                    n_a   = r_hi;
                    n_mid = clip_to_block(t_ptr'(r_hi) + t_ptr'(r_w));
                    n_b   = clip_to_block(t_ptr'(r_hi) + t_ptr'(r_w));
                    n_hi  = clip_to_block(t_ptr'(r_hi) + dbl_w);
                end
            end
            S_EPRIME: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                n_a = r_a + t_cnt'(1);
                if (r_a == LAST_IDX) begin
                    n_state = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_LOAD;
            r_load_cnt <= '0;
            r_a        <= '0;
            r_b        <= '0;
            r_mid      <= '0;
            r_hi       <= '0;
            r_wp       <= '0;
            r_w        <= '0;
            r_src      <= 1'b0;
            r_o_valid  <= 1'b0;
            r_o_last   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_load_cnt <= n_load_cnt;
            r_a        <= n_a;
            r_b        <= n_b;
            r_mid      <= n_mid;
            r_hi       <= n_hi;
            r_wp       <= n_wp;
            r_w        <= n_w;
            r_src      <= n_src;
            r_o_valid  <= (r_state == S_EMIT);
            r_o_last   <= (r_state == S_EMIT) && (r_a == LAST_IDX);
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_byte <= qa;
    end

    assign o_valid         = r_o_valid;
    assign o_sorted_byte   = r_o_byte;
    assign o_last_of_block = r_o_last;

    a_valid_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> $past(r_state == S_EMIT))
        else $error("Result strobe without a preceding emit cycle.");

    a_last_has_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last_of_block |-> o_valid)
        else $error("Last-of-block flag raised without a result.");

    a_merge_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MERGE) |-> ((r_a <= r_mid) && (r_b <= r_hi) && (r_hi <= BLOCK_N)))
        else $error("Merge pointer ran past its run boundary.");

    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last_of_block |=> !o_valid)
        else $error("Result strobe directly after the end of a block.");

endmodule

// ===== tb/sv/byte_block_merge_sorter_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte block merge sorter testbench
// Loads blocks of bytes into the sorter and checks every sorted byte and its
// end-of-block flag against a merge sort computed inside the testbench.
// Directed blocks with extreme values and ties are followed by random, ordered,
// tie-heavy and partial blocks, with random gaps between load transactions.
// ----------------------------------------------------------------------------
module byte_block_merge_sorter_test;
    import bbms_pkg::*;

    localparam int IDLE_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 120;

    typedef struct {
        t_byte value;
        logic  last;
    } t_sorted_entry;

    logic  i_clk = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  start = 1'b0;
    t_byte i_data_byte = '0;
    logic  busy;
    logic  o_valid;
    t_byte o_sorted_byte;
    logic  o_last_of_block;

    t_sorted_entry sorted_expected[$];
    t_byte block_bytes[BLOCK_SIZE];
    int bytes_loaded = 0;
    int bytes_sent = 0;
    int bytes_checked = 0;
    int blocks_sorted = 0;
    int error_count = 0;
    int idle_cycles = 0;
    int burst_left = 0;
    bit gaps_enabled = 1'b1;

    byte_block_merge_sorter dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .i_data_byte     (i_data_byte),
        .busy            (busy),
        .o_valid         (o_valid),
        .o_sorted_byte   (o_sorted_byte),
        .o_last_of_block (o_last_of_block)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Bottom-up merge sort of the loaded block, stable on equal values.
    task automatic sort_block_into_queue();
        t_byte run_bytes[BLOCK_SIZE];
        t_byte merged[BLOCK_SIZE];
        t_sorted_entry entry;
        int width, lo, mid, hi, a, b, w;
        run_bytes = block_bytes;
        for (width = 1; width < BLOCK_SIZE; width = width * 2) begin
            for (lo = 0; lo + width < BLOCK_SIZE; lo = lo + 2 * width) begin
                mid = lo + width;
                hi = (mid + width > BLOCK_SIZE) ? BLOCK_SIZE : mid + width;
                a = lo;
                b = mid;
                for (w = lo; w < hi; w++) begin
                    if (b >= hi || (a < mid && run_bytes[a] <= run_bytes[b])) begin
                        merged[w] = run_bytes[a];
                        a++;
                    end else begin
                        merged[w] = run_bytes[b];
                        b++;
                    end
                end
                for (w = lo; w < hi; w++) begin
                    run_bytes[w] = merged[w];
                end
            end
        end
        for (w = 0; w < BLOCK_SIZE; w++) begin
            entry.value = run_bytes[w];
            entry.last = (w == BLOCK_SIZE - 1);
            sorted_expected.push_back(entry);
        end
        blocks_sorted++;
    endtask

    task automatic load_byte_model(input t_byte value);
        block_bytes[bytes_loaded] = value;
        bytes_loaded++;
        if (bytes_loaded == BLOCK_SIZE) begin
            sort_block_into_queue();
            bytes_loaded = 0;
        end
    endtask

    task automatic pace_sender();
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = gaps_enabled ? $urandom_range(0, 12) : 0;
            if (gap != 0) begin
                start <= 1'b0;
                i_data_byte <= t_byte'($urandom);
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
    endtask

    // Holds start high until the sorter takes the byte.
    task automatic send_byte(input t_byte value);
        pace_sender();
        start <= 1'b1;
        i_data_byte <= value;
        do begin
            @(posedge i_clk);
        end while (busy);
        load_byte_model(value);
        bytes_sent++;
    endtask

    task automatic test_extremes_and_ties();
        t_byte pattern[16] = '{8'hFF, 8'h00, 8'h80, 8'h7F, 8'h00, 8'hFF, 8'h01, 8'hFE,
                               8'h55, 8'hAA, 8'h80, 8'h80, 8'h07, 8'h00, 8'hFF, 8'h40};
        int k;
        gaps_enabled = 1'b0;
        for (k = 0; k < BLOCK_SIZE; k++) begin
            send_byte(pattern[k % 16]);
        end
        gaps_enabled = 1'b1;
        for (k = 0; k < BLOCK_SIZE; k++) begin
            send_byte(t_byte'(8'hFF - k));
        end
    endtask

    task automatic test_uniform_blocks(input int block_count);
        int n, k;
        for (n = 0; n < block_count; n++) begin
            gaps_enabled = ($urandom_range(0, 3) != 0);
            for (k = 0; k < BLOCK_SIZE; k++) begin
                send_byte(t_byte'($urandom));
            end
        end
        gaps_enabled = 1'b1;
    endtask

    task automatic test_ordered_blocks(input int block_count);
        int n, k, base, step;
        for (n = 0; n < block_count; n++) begin
            base = $urandom_range(0, 255);
            step = $urandom_range(0, 3);
            for (k = 0; k < BLOCK_SIZE; k++) begin
                case (n % 3)
                    0: send_byte(t_byte'(base + k * step));
                    1: send_byte(t_byte'(base - k * step));
                    default: send_byte(t_byte'(base));
                endcase
            end
        end
    endtask

    task automatic test_tie_heavy_blocks(input int block_count);
        t_byte choices[3];
        int n, k;
        for (n = 0; n < block_count; n++) begin
            foreach (choices[c]) choices[c] = t_byte'($urandom);
            for (k = 0; k < BLOCK_SIZE; k++) begin
                send_byte(choices[$urandom_range(0, 2)]);
            end
        end
    endtask

    task automatic test_partial_block();
        int k, count;
        count = $urandom_range(1, BLOCK_SIZE - 1);
        for (k = 0; k < count; k++) begin
            send_byte(t_byte'($urandom));
        end
    endtask

    always @(posedge i_clk) begin
        t_sorted_entry want;
        if (i_rst_n && o_valid) begin
            if (sorted_expected.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual byte %0d last %0b",
                         $time, o_sorted_byte, o_last_of_block);
                error_count++;
            end else begin
                want = sorted_expected.pop_front();
                if (o_sorted_byte !== want.value) begin
                    $display("%0t: sorted_byte mismatch, expected %0d, actual %0d",
                             $time, want.value, o_sorted_byte);
                    error_count++;
                end
                if (o_last_of_block !== want.last) begin
                    $display("%0t: last_of_block mismatch, expected %0b, actual %0b",
                             $time, want.last, o_last_of_block);
                    error_count++;
                end
                bytes_checked++;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles without a transaction", $time, IDLE_LIMIT);
            $display("Verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_extremes_and_ties();
        test_uniform_blocks(12);
        test_ordered_blocks(8);
        test_tie_heavy_blocks(8);
        test_partial_block();

        start <= 1'b0;
        while (sorted_expected.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sorted_expected.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, sorted_expected.size());
            error_count++;
        end

        $display("Loaded %0d bytes and checked %0d sorted bytes from %0d blocks.",
                 bytes_sent, bytes_checked, blocks_sorted);
        $display("Blocks covered extremes, ties, ordered runs and a trailing partial block.");
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
